>>> hdl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg: shared types and constants for the alcohol concentration core
// Holds field widths, status codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam int AdcBits = 10;
  localparam int BlowW   = 7;
  localparam int ConcW   = 16;
  localparam int QDepth  = 2;
  localparam int IdxW    = 2;

  // heater supply times three, in adc counts
  localparam logic [AdcBits+1:0] H3 = (AdcBits+2)'(5 << (AdcBits - 1));

  localparam logic [1:0] StValid  = 2'd0;
  localparam logic [1:0] StBlows  = 2'd1;
  localparam logic [1:0] StSpan   = 2'd2;

  localparam logic [IdxW-1:0] RegCalBase = 2'd0;
  localparam logic [IdxW-1:0] RegCalGas  = 2'd1;
  localparam logic [IdxW-1:0] RegMinBlow = 2'd2;
  localparam logic [IdxW-1:0] RegColdEn  = 2'd3;

  typedef logic [AdcBits-1:0] adc_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic [1:0] status;
    adc_t       drop;
    adc_t       span;
    adc_t       vc;
    adc_t       vb;
    adc_t       va;
    logic       cold;
  } acc_req_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV1, BK_DIV3, BK_COMP, BK_CORR, BK_OUT
  } bk_state_t;

endpackage

>>> hdl/alcohol_concentration_calc_core.sv
// ----------------------------------------------------------------------------
// alcohol_concentration_calc_core: breath alcohol concentration calculator
// Configuration registers, request front end and serial compute back end.
// ----------------------------------------------------------------------------
// One result per measurement. The back end takes a request, then runs two
// 18-step serial divisions (ppm, cold ratio), with mg formed by a reciprocal
// multiply at the end of the first, then compensation, correction and output.
// A result left waiting on out_tready holds the back end for as long as it
// waits; a two-entry queue lets the front keep accepting meanwhile. Write
// configuration only while idle.
module alcohol_concentration_calc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // blow_count, baseline_voltage, breath_voltage, cold_voltage, cold_flag
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, concentration, alcohol_level, lock_request
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  acc_pkg::adc_t             cal_base_r, cal_gas_r;
  logic [acc_pkg::BlowW-1:0] min_blows_r;
  logic                      cold_en_r;
  logic                      q_valid, q_pop;
  acc_pkg::acc_req_t         q_head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_base_r  <= 10'd600;
      cal_gas_r   <= 10'd400;
      min_blows_r <= 7'd5;
      cold_en_r   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acc_pkg::RegCalBase: cal_base_r  <= cfg_data[9:0];
        acc_pkg::RegCalGas:  cal_gas_r   <= cfg_data[9:0];
        acc_pkg::RegMinBlow: min_blows_r <= cfg_data[6:0];
        acc_pkg::RegColdEn:  cold_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  acc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cal_base(cal_base_r), .cal_gas(cal_gas_r), .min_blows(min_blows_r),
    .q_valid, .q_pop, .q_head
  );

  acc_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head,
    .cal_base(cal_base_r), .cold_en(cold_en_r),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

>>> hdl/acc_front.sv
// ----------------------------------------------------------------------------
// acc_front: accepts measurement requests and classifies them
// Checks blow count and calibration span, clamps the breath reading and
// pushes a request record into a small queue for the back end.
// ----------------------------------------------------------------------------
module acc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,
  input  acc_pkg::adc_t                cal_base,
  input  acc_pkg::adc_t                cal_gas,
  input  logic [acc_pkg::BlowW-1:0]    min_blows,
  output logic                         q_valid,
  input  logic                         q_pop,
  output acc_pkg::acc_req_t            q_head
);

  acc_pkg::acc_req_t q_mem_r [acc_pkg::QDepth];
  logic              wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  acc_pkg::acc_req_t rec;
  logic [acc_pkg::BlowW-1:0] blows;
  acc_pkg::adc_t vb, vc, va;
  logic push;

  // field unpack
  assign blows = in_tdata[6:0];
  assign vb    = in_tdata[16:7];
  assign vc    = in_tdata[26:17];
  assign va    = in_tdata[36:27];

  assign in_tready = (cnt_r != 2'(acc_pkg::QDepth));
  assign push      = in_tvalid && in_tready;

  // classify
  always_comb begin
    rec.vb   = vb;
    rec.va   = va;
    rec.cold = in_tdata[37];
    rec.vc   = (vc > cal_base) ? cal_base : vc;
    rec.drop = cal_base - rec.vc;
    rec.span = cal_base - cal_gas;
    if (blows < min_blows) begin
      rec.status = acc_pkg::StBlows;
    end else if (cal_gas >= cal_base) begin
      rec.status = acc_pkg::StSpan;
    end else begin
      rec.status = acc_pkg::StValid;
    end
  end

  // queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= rec;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rp_r];

endmodule

>>> hdl/acc_back.sv
// ----------------------------------------------------------------------------
// acc_back: computes concentration for one request at a time
// Serial dividers for ppm and the cold ratio, reciprocal multiplies for the
// constant divisions, then compensation, piecewise correction, level
// classification and an output register.
// ----------------------------------------------------------------------------
module acc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  acc_pkg::acc_req_t    q_head,
  input  acc_pkg::adc_t        cal_base,
  input  logic                 cold_en,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata
);

  localparam int NumW = 18;  // 130*1023 fits in 18 bits
  localparam int DenW = 12;
  localparam int RecipSh = 22;
  // floor(x/10) and floor(x/100) as (x*m) >> 22, exact for x below 2^19 and below 43699 respectively
  localparam logic [18:0] Recip10  = 19'd419431;
  localparam logic [18:0] Recip100 = 19'd41944;
  // floor(ppm*10/26) as (ppm*m) >> 20, exact for any 16-bit ppm
  localparam logic [18:0] RecipMg  = 19'd403299;

  acc_pkg::bk_state_t st_r, st_nxt;
  acc_pkg::acc_req_t  req_r;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic [4:0]      bit_r, bit_nxt;
  logic [15:0]     mg_r;
  logic [15:0]     t1_r;
  logic [2:0]      ccnt_r, ccnt_nxt;
  logic [18:0]     prod_r, prod_nxt;
  logic            scale_r, scale_nxt;
  logic            cent_r, cent_nxt;
  logic [15:0]     ppm_sat;
  logic [34:0]     mg_mul;
  logic [37:0]     recip;
  logic [18:0]     corr_w;
  logic [15:0]     corr;
  logic [1:0]      level;
  logic            out_valid_r;
  logic [23:0]     out_data_r;
  logic            div_done;
  logic [DenW:0]   rem_sh;
  logic            drifted, zero_mg, vge;
  logic [11:0]     b3, a3, hb, ha;
  logic [27:0]     lhs;
  logic [17:0]     rhs;

  assign b3 = 12'(3 * cal_base);
  assign a3 = 12'(3 * req_r.va);
  assign hb = 12'(acc_pkg::H3) - b3;
  assign ha = 12'(acc_pkg::H3) - a3;

  // restoring division step, one quotient bit per cycle
  assign rem_sh   = {rem_r[DenW-1:0], quo_r[NumW-1]};
  assign div_done = (bit_r == 5'd0);

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    bit_nxt = bit_r;
    if (st_r == acc_pkg::BK_DIV1 || st_r == acc_pkg::BK_DIV3) begin
      if (!div_done) begin
        bit_nxt = bit_r - 5'd1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[NumW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[NumW-2:0], 1'b0};
        end
      end
    end
  end

  // ppm saturated to 16 bits, then mg = ppm*10/26
  assign ppm_sat = (quo_r > 18'h0FFFF) ? 16'hFFFF : quo_r[15:0];
  assign mg_mul  = 35'(ppm_sat) * 35'(RecipMg);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      acc_pkg::BK_IDLE: if (q_valid) st_nxt = acc_pkg::BK_DIV1;
      acc_pkg::BK_DIV1: if (div_done) st_nxt = acc_pkg::BK_DIV3;
      acc_pkg::BK_DIV3: if (div_done) st_nxt = acc_pkg::BK_COMP;
      acc_pkg::BK_COMP: st_nxt = acc_pkg::BK_CORR;
      acc_pkg::BK_CORR: st_nxt = acc_pkg::BK_OUT;
      acc_pkg::BK_OUT:  if (!out_valid_r || out_tready) st_nxt = acc_pkg::BK_IDLE;
      default:          st_nxt = acc_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = (st_r == acc_pkg::BK_IDLE) && q_valid;
  end

  // drift test and compensation
  assign lhs = 28'(t1_r) * 28'(ha);
  assign rhs = 18'(30 * req_r.va);
  assign drifted = (b3 < 12'(acc_pkg::H3)) && (a3 < 12'(acc_pkg::H3)) &&
                   (t1_r != 16'd0) && (lhs >= 28'(rhs));
  assign vge = (req_r.vc >= req_r.vb);

  always_comb begin
    ccnt_nxt = ccnt_r;
    zero_mg  = 1'b0;
    if (cold_en) begin
      if (drifted) begin
        ccnt_nxt = 3'd1;
      end else begin
        ccnt_nxt = ccnt_r + 3'd1;
        if (ccnt_nxt == 3'd1) begin
          ccnt_nxt = 3'd0;
        end else if (ccnt_nxt <= 3'd3) begin
          zero_mg = vge;
        end else if (ccnt_nxt == 3'd4) begin
          zero_mg  = vge;
          ccnt_nxt = 3'd0;
        end
      end
      if (req_r.cold && vge) zero_mg = 1'b1;
    end
  end

  // piecewise correction, numerator product and divisor select
  always_comb begin
    scale_nxt = 1'b1;
    cent_nxt  = 1'b0;
    if (mg_r <= 16'd35) begin
      prod_nxt = 19'(mg_r) * 19'd7;
    end else if (mg_r <= 16'd40) begin
      prod_nxt = 19'(mg_r) * 19'd8;
    end else if (mg_r <= 16'd45) begin
      prod_nxt = 19'(mg_r) * 19'd95;
      cent_nxt = 1'b1;
    end else if (mg_r <= 16'd56) begin
      prod_nxt  = 19'(mg_r);
      scale_nxt = 1'b0;
    end else if (mg_r <= 16'd66) begin
      prod_nxt = 19'(mg_r) * 19'd105;
      cent_nxt = 1'b1;
    end else if (mg_r <= 16'd100) begin
      prod_nxt = 19'(mg_r) * 19'd12;
    end else begin
      prod_nxt = 19'(mg_r) * 19'd13;
    end
  end

  // constant division by reciprocal, saturation and level
  always_comb begin
    recip  = 38'(prod_r) * 38'(cent_r ? Recip100 : Recip10);
    corr_w = scale_r ? 19'(recip[37:RecipSh]) : prod_r;
    corr   = (corr_w > 19'h0FFFF) ? 16'hFFFF : corr_w[15:0];
    if (corr >= 16'd80)      level = 2'd3;
    else if (corr >= 16'd40) level = 2'd2;
    else if (corr >= 16'd18) level = 2'd1;
    else                     level = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= acc_pkg::BK_IDLE;
      ccnt_r      <= 3'd0;
      out_valid_r <= 1'b0;
      bit_r       <= 5'd0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && out_tready && st_r != acc_pkg::BK_OUT) out_valid_r <= 1'b0;
      unique case (st_r)
        acc_pkg::BK_IDLE: begin
          if (q_valid) begin
            req_r <= q_head;
            bit_r <= 5'(NumW);
            quo_r <= 18'(130 * q_head.drop);
            rem_r <= '0;
            den_r <= 12'(q_head.span);
          end
        end
        acc_pkg::BK_DIV1: begin
          if (div_done) begin
            mg_r  <= 16'(mg_mul[34:20]);
            quo_r <= 18'(b3);
            rem_r <= '0;
            den_r <= (b3 < 12'(acc_pkg::H3)) ? hb : 12'd1;
            bit_r <= 5'(NumW);
          end else begin
            quo_r <= quo_nxt;
            rem_r <= rem_nxt;
            bit_r <= bit_nxt;
          end
        end
        acc_pkg::BK_DIV3: begin
          if (div_done) begin
            t1_r <= 16'(quo_r);
          end else begin
            quo_r <= quo_nxt;
            rem_r <= rem_nxt;
            bit_r <= bit_nxt;
          end
        end
        acc_pkg::BK_COMP: begin
          if (req_r.status == acc_pkg::StValid) begin
            ccnt_r <= ccnt_nxt;
            if (zero_mg) mg_r <= 16'd0;
          end
        end
        acc_pkg::BK_CORR: begin
          prod_r  <= prod_nxt;
          scale_r <= scale_nxt;
          cent_r  <= cent_nxt;
        end
        acc_pkg::BK_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (req_r.status == acc_pkg::StValid) begin
              out_data_r <= {3'b0, (level != 2'd0), level, corr, acc_pkg::StValid};
            end else begin
              out_data_r <= {22'd0, req_r.status};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for alcohol_concentration_calc_core
// Streams breath test requests through the core under random idling on both
// sides, predicts every result in a scoreboard and compares them field by
// field, stepping through several calibration settings between phases.
// ----------------------------------------------------------------------------
module tb_top;

  // one expected result
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] conc;
    logic [1:0]  level;
    logic        lock;
  } acc_res_t;

  // scoreboard with its own copy of the calibration and cold counter
  class acc_scoreboard;
    int unsigned cal_base, cal_gas, min_blows, cold_en;
    logic [2:0]  cold_cnt;
    acc_res_t    pending[$];
    int          errors;

    function new();
      cal_base = 600; cal_gas = 400; min_blows = 5; cold_en = 1;
      cold_cnt = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        acc_pkg::RegCalBase: cal_base = val[9:0];
        acc_pkg::RegCalGas:  cal_gas  = val[9:0];
        acc_pkg::RegMinBlow: min_blows = val[6:0];
        acc_pkg::RegColdEn:  cold_en  = val[0];
        default: ;
      endcase
    endfunction

    function bit drifted(int unsigned base, int unsigned cv);
      longint unsigned h3, b3, a3, t1;
      h3 = 64'd5 << (acc_pkg::AdcBits - 1);
      b3 = 3 * base;
      a3 = 3 * cv;
      if (b3 >= h3 || a3 >= h3) return 0;
      t1 = b3 / (h3 - b3);
      if (t1 == 0) return 0;
      return t1 * (h3 - a3) >= 30 * longint'(cv);
    endfunction

    function int unsigned piecewise(int unsigned mg);
      int unsigned r;
      if (mg <= 35) r = mg * 7 / 10;
      else if (mg <= 40) r = mg * 8 / 10;
      else if (mg <= 45) r = mg * 95 / 100;
      else if (mg <= 56) r = mg;
      else if (mg <= 66) r = mg * 105 / 100;
      else if (mg <= 100) r = mg * 12 / 10;
      else r = mg * 13 / 10;
      return (r > 65535) ? 65535 : r;
    endfunction

    // accepted request: work out its result
    function void note_request(logic [39:0] d);
      int unsigned blows, vb, vc, va, span, drop, ppm, mg;
      logic        cold;
      acc_res_t    r;
      blows = d[6:0]; vb = d[16:7]; vc = d[26:17]; va = d[36:27]; cold = d[37];
      r = '0;
      if (blows < min_blows) begin
        r.status = acc_pkg::StBlows;
      end else if (cal_gas >= cal_base) begin
        r.status = acc_pkg::StSpan;
      end else begin
        r.status = acc_pkg::StValid;
        span = cal_base - cal_gas;
        if (vc > cal_base) vc = cal_base;
        drop = cal_base - vc;
        ppm = 130 * drop / span;
        if (ppm > 65535) ppm = 65535;
        mg = ppm * 10 / 26;
        if (cold_en != 0) begin
          if (drifted(cal_base, va)) begin
            cold_cnt = 1;
          end else begin
            cold_cnt = cold_cnt + 3'd1;
            if (cold_cnt == 1) cold_cnt = 0;
            else if (cold_cnt <= 3) begin
              if (vc >= vb) mg = 0;
            end else if (cold_cnt == 4) begin
              if (vc >= vb) mg = 0;
              cold_cnt = 0;
            end
          end
          if (cold && vc >= vb) mg = 0;
        end
        mg = piecewise(mg);
        r.conc = mg[15:0];
        r.level = (mg >= 80) ? 2'd3 : (mg >= 40) ? 2'd2 : (mg >= 18) ? 2'd1 : 2'd0;
        r.lock = (r.level != 0);
      end
      pending.push_back(r);
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(logic [23:0] d);
      acc_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[1:0]);
        errors++;
      end
      if (d[17:2] !== e.conc) begin
        $display("%0t: concentration expected %0d actual %0d", $time, e.conc, d[17:2]);
        errors++;
      end
      if (d[19:18] !== e.level) begin
        $display("%0t: level expected %0d actual %0d", $time, e.level, d[19:18]);
        errors++;
      end
      if (d[20] !== e.lock) begin
        $display("%0t: lock expected %0d actual %0d", $time, e.lock, d[20]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  bit          calm = 0;

  acc_scoreboard sb = new();

  alcohol_concentration_calc_core dut (.*);

  always #1 clk = ~clk;

  // result side: random stalls, check on each accepted result
  always @(negedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 18);
  always @(posedge clk) if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  // valid stays high after acceptance until the next idle or drain drops it
  task automatic send_request(logic [6:0] blows, logic [9:0] vb, logic [9:0] vc,
                              logic [9:0] va, logic cold);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b0, cold, va, vc, vb, blows};
    do @(posedge clk); while (!in_tready);
    sb.note_request(in_tdata);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic setup(int unsigned base, int unsigned gas, int unsigned mb, int unsigned en);
    wait_drained();
    write_reg(acc_pkg::RegCalBase, {6'($urandom_range(0, 63)), base[9:0]});
    write_reg(acc_pkg::RegCalGas, {6'($urandom_range(0, 63)), gas[9:0]});
    write_reg(acc_pkg::RegMinBlow, {9'($urandom_range(0, 511)), mb[6:0]});
    write_reg(acc_pkg::RegColdEn, {15'($urandom_range(0, 32767)), en[0]});
    cfg_valid <= 0;
  endtask

  task automatic random_requests(int n);
    logic [6:0] blows;
    logic [9:0] vb, vc, va;
    for (int i = 0; i < n; i++) begin
      blows = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(sb.min_blows, 127));
      vb = 10'($urandom_range(0, 1023));
      vc = ($urandom_range(0, 3) == 0) ? 10'(vb + $urandom_range(0, 6) - 3)
                                       : 10'($urandom_range(0, 1023));
      va = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 300))
                                       : 10'($urandom_range(0, 1023));
      send_request(blows, vb, vc, va, 1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: default calibration
    send_request(7'd0, 10'd500, 10'd100, 10'd500, 1'b0);
    send_request(7'd4, 10'd500, 10'd100, 10'd500, 1'b0);
    send_request(7'd5, 10'd1023, 10'd0, 10'd0, 1'b0);
    send_request(7'd127, 10'd0, 10'd1023, 10'd1023, 1'b1);
    send_request(7'd20, 10'd300, 10'd500, 10'd1023, 1'b0);
    send_request(7'd20, 10'd300, 10'd500, 10'd1023, 1'b0);
    send_request(7'd20, 10'd300, 10'd500, 10'd1023, 1'b0);
    send_request(7'd20, 10'd300, 10'd500, 10'd1023, 1'b0);
    send_request(7'd20, 10'd300, 10'd580, 10'd1023, 1'b1);
    send_request(7'd20, 10'd700, 10'd560, 10'd900, 1'b0);
    send_request(7'd20, 10'd700, 10'd540, 10'd900, 1'b0);
    // calibration base at full scale, above heater supply, widest span
    setup(1023, 0, 0, 1);
    send_request(7'd0, 10'd1023, 10'd0, 10'd0, 1'b0);
    send_request(7'd0, 10'd0, 10'd1023, 10'd0, 1'b1);
    send_request(7'd0, 10'd500, 10'd1000, 10'd1023, 1'b0);
    // tiny span, saturating ppm
    setup(853, 852, 127, 1);
    send_request(7'd127, 10'd1023, 10'd0, 10'd0, 1'b0);
    send_request(7'd126, 10'd1023, 10'd0, 10'd0, 1'b0);
    // span not positive
    setup(500, 500, 0, 1);
    send_request(7'd0, 10'd100, 10'd100, 10'd100, 1'b1);
    // t1 zero
    setup(100, 0, 0, 1);
    send_request(7'd3, 10'd50, 10'd60, 10'd10, 1'b0);
    send_request(7'd3, 10'd50, 10'd60, 10'd10, 1'b1);
    // compensation off
    setup(800, 100, 1, 0);
    send_request(7'd1, 10'd200, 10'd400, 10'd0, 1'b1);
    send_request(7'd1, 10'd200, 10'd700, 10'd0, 1'b0);

    // random phases over a range of calibrations
    setup(600, 400, 5, 1);
    calm = 1;
    random_requests(40);
    calm = 0;
    random_requests(50);
    setup(1023, 0, 0, 1);
    random_requests(80);
    setup(800, 790, 127, 1);
    random_requests(60);
    setup(427, 0, 10, 1);
    random_requests(80);
    setup(700, 300, 3, 0);
    random_requests(70);
    setup(400, 900, 0, 1);
    random_requests(30);
    setup(0, 0, 0, 0);
    random_requests(20);
    setup($urandom_range(430, 850), $urandom_range(0, 400), $urandom_range(0, 20), 1);
    random_requests(100);

    wait_drained();
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("** alcohol_concentration_calc_core: PASSED **");
    end else begin
      $display("** alcohol_concentration_calc_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** alcohol_concentration_calc_core: FAILED **");
    $finish;
  end
endmodule

>>> sim.f
hdl/acc_pkg.sv
hdl/acc_front.sv
hdl/acc_back.sv
hdl/alcohol_concentration_calc_core.sv
tb/tb_top.sv
